// ===== rtl/core/mdt_pkg.sv =====
// Package for the MIDI drum channel tracker: sizes, codes, reset-message
// byte patterns and the types passed between the tracker's modules.
// No dependencies.
`default_nettype none

package mdt_pkg;

  localparam int CHANNELS  = 16;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int HOLD_LEN  = 11;
  localparam int HOLD_W    = $clog2(HOLD_LEN);
  localparam int COUNT_SAT = 12;
  localparam int NUM_PAT   = 5;

  // synth modes
  localparam logic [1:0] MODE_GM  = 2'd0;
  localparam logic [1:0] MODE_GM2 = 2'd1;
  localparam logic [1:0] MODE_GS  = 2'd2;
  localparam logic [1:0] MODE_XG  = 2'd3;

  // short message codes
  localparam logic [3:0] STATUS_CTRL = 4'hB;
  localparam logic [3:0] STATUS_PROG = 4'hC;
  localparam logic [7:0] CC_BANK     = 8'h00;
  localparam logic [7:0] XG_DRUM     = 8'h7F;
  localparam logic [7:0] GM2_DRUM    = 8'h78;
  localparam logic [7:0] GM2_MELODIC = 8'h79;

  // GS part message address bytes
  localparam logic [7:0] GS_ADDR_MAP  = 8'h02;
  localparam logic [7:0] GS_ADDR_DRUM = 8'h15;

  localparam logic [CH_W-1:0] DRUM_CH = CH_W'(9);

  // pattern indexes
  localparam logic [2:0] PAT_GM   = 3'd0;
  localparam logic [2:0] PAT_GM2  = 3'd1;
  localparam logic [2:0] PAT_GS   = 3'd2;
  localparam logic [2:0] PAT_XG   = 3'd3;
  localparam logic [2:0] PAT_PART = 3'd4;

  localparam logic [3:0] LEN_GM = 4'd6;
  localparam logic [3:0] LEN_GS = 4'd11;
  localparam logic [3:0] LEN_XG = 4'd9;

  typedef enum logic [2:0] {
    TBL_NONE,
    TBL_RESTORE,
    TBL_FLAG,
    TBL_MAP,
    TBL_FLAG_MAPPED
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e         op;
    logic [CH_W-1:0] idx;
    logic [7:0]      val;
  } tbl_cmd_t;

  typedef struct packed {
    logic            done;
    logic            rst_hit;
    logic [1:0]      rst_mode;
    logic            part_hit;
    logic [CH_W-1:0] part;
    logic [7:0]      addr;
    logic [7:0]      value;
  } match_res_t;

  // Default part-to-channel map.
  function automatic logic [7:0] map_init(input logic [CH_W-1:0] idx);
    logic [7:0] r;
    if (idx == 4'd0) begin
      r = 8'd9;
    end else if (idx <= 4'd9) begin
      r = 8'(idx) - 8'd1;
    end else begin
      r = 8'(idx);
    end
    return r;
  endfunction

  // Returns {mask, value}; a byte matches when (byte & mask) == value.
  function automatic logic [15:0] pat_entry(input logic [2:0] kind,
                                            input logic [HOLD_W-1:0] idx);
    logic [15:0] r;
    r = 16'h0000;
    unique case (kind)
      PAT_GM, PAT_GM2: begin
        unique case (idx)
          4'd0:    r = 16'hFFF0;
          4'd1:    r = 16'hFF7E;
          4'd2:    r = 16'hFF7F;
          4'd3:    r = 16'hFF09;
          4'd4:    r = (kind == PAT_GM) ? 16'hFF01 : 16'hFF03;
          4'd5:    r = 16'hFFF7;
          default: r = 16'h0000;
        endcase
      end
      PAT_GS: begin
        unique case (idx)
          4'd0:    r = 16'hFFF0;
          4'd1:    r = 16'hFF41;
          4'd2:    r = 16'hFF10;
          4'd3:    r = 16'hFF42;
          4'd4:    r = 16'hFF12;
          4'd5:    r = 16'hFF40;
          4'd6:    r = 16'hFF00;
          4'd7:    r = 16'hFF7F;
          4'd8:    r = 16'hFF00;
          4'd9:    r = 16'hFF41;
          4'd10:   r = 16'hFFF7;
          default: r = 16'h0000;
        endcase
      end
      PAT_XG: begin
        unique case (idx)
          4'd0:    r = 16'hFFF0;
          4'd1:    r = 16'hFF43;
          4'd2:    r = 16'hFF10;
          4'd3:    r = 16'hFF4C;
          4'd4:    r = 16'hFF00;
          4'd5:    r = 16'hFF00;
          4'd6:    r = 16'hFF7E;
          4'd7:    r = 16'hFF00;
          4'd8:    r = 16'hFFF7;
          default: r = 16'h0000;
        endcase
      end
      PAT_PART: begin
        // F0 41 xx 42 12 40 1p xx xx xx F7
        unique case (idx)
          4'd0:    r = 16'hFFF0;
          4'd1:    r = 16'hFF41;
          4'd3:    r = 16'hFF42;
          4'd4:    r = 16'hFF12;
          4'd5:    r = 16'hFF40;
          4'd6:    r = 16'hF010;
          4'd10:   r = 16'hFFF7;
          default: r = 16'h0000;
        endcase
      end
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/midi_drum_channel_tracker.sv =====
// Top level of the MIDI drum channel tracker: sequencer, mode register and
// result register. Depends on mdt_pkg, mdt_matcher and mdt_chan_tbl.
//
// Follows the synth mode (GM, GM2, GS, XG) and a drum setting per MIDI
// channel. An input item is either a packed short message (func 0) or one
// sysex byte (func 1). Short messages and non-final sysex bytes leave the
// sequencer idle; a program change loads one result into the output register
// at the accepting edge. The final sysex byte starts a byte-serial scan of
// the held message, one byte per cycle through the matcher's compare unit,
// and the block is stalled until the scan is done. A matching reset message
// then emits 16 results, channels 0..15, one per cycle while the output side
// is not stalling. Input stall is high whenever the sequencer is busy or the
// output register is full and stalled.
`default_nettype none

module midi_drum_channel_tracker
  import mdt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [23:0] short_word_i,
  input  wire logic [7:0]  sysex_byte_i,
  input  wire logic        byte_last_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       drum_ch_o,
  output logic [7:0]       drum_value_o,
  output logic [1:0]       mode_now_o,
  output logic             last_in_run_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_BURST = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      mode_q;
  logic [CH_W-1:0] burst_q;

  logic            out_valid_q;
  logic [CH_W-1:0] out_ch_q;
  logic [7:0]      out_val_q;
  logic [1:0]      out_mode_q;
  logic            out_last_q;

  logic            out_free, in_acc;
  logic            is_prog, is_cc0, byte_we, burst_load;
  logic [3:0]      kind;
  logic [CH_W-1:0] ch;
  logic [7:0]      d1, d2;
  logic [CH_W-1:0] rd_ch;
  logic [7:0]      rd_val;
  match_res_t      mres;
  tbl_cmd_t        cmd;

  assign kind = short_word_i[7:4];
  assign ch   = short_word_i[CH_W-1:0];
  assign d1   = short_word_i[15:8];
  assign d2   = short_word_i[23:16];

  // output register frees up when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_prog    = in_acc && !func_i && (kind == STATUS_PROG);
  assign is_cc0     = in_acc && !func_i && (kind == STATUS_CTRL) && (d1 == CC_BANK);
  assign byte_we    = in_acc && func_i;
  assign burst_load = (state_q == S_BURST) && out_free;

  assign rd_ch = (state_q == S_BURST) ? burst_q : ch;

  mdt_matcher u_matcher (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_we_i (byte_we),
    .byte_i    (sysex_byte_i),
    .last_i    (byte_last_i),
    .res_o     (mres)
  );

  mdt_chan_tbl u_tbl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .rd_ch_i  (rd_ch),
    .rd_val_o (rd_val)
  );

  // table updates: scan verdicts and bank-select controllers
  always_comb begin
    cmd.op  = TBL_NONE;
    cmd.idx = ch;
    cmd.val = 8'd0;
    if ((state_q == S_SCAN) && mres.done) begin
      if (mres.rst_hit) begin
        cmd.op = TBL_RESTORE;
      end else if (mres.part_hit && (mode_q == MODE_GS)) begin
        cmd.idx = mres.part;
        cmd.val = mres.value;
        if (mres.addr == GS_ADDR_MAP) begin
          cmd.op = TBL_MAP;
        end else if (mres.addr == GS_ADDR_DRUM) begin
          cmd.op = TBL_FLAG_MAPPED;
        end
      end
    end else if (is_cc0) begin
      if (mode_q == MODE_XG) begin
        cmd.op  = TBL_FLAG;
        cmd.val = (d2 == XG_DRUM) ? 8'd1 : 8'd0;
      end else if (mode_q == MODE_GM2) begin
        if (d2 == GM2_DRUM) begin
          cmd.op  = TBL_FLAG;
          cmd.val = 8'd1;
        end else if (d2 == GM2_MELODIC) begin
          cmd.op  = TBL_FLAG;
          cmd.val = 8'd0;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (byte_we && byte_last_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (mres.done) begin
          state_d = mres.rst_hit ? S_BURST : S_IDLE;
        end
      end
      S_BURST: begin
        if (out_free && (burst_q == CH_W'(CHANNELS - 1))) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_GM;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_SCAN) && mres.done && mres.rst_hit) begin
        mode_q  <= mres.rst_mode;
        burst_q <= '0;
      end else if (burst_load) begin
        burst_q <= burst_q + CH_W'(1);
      end
      if (is_prog || burst_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (is_prog || burst_load) begin
      out_ch_q   <= rd_ch;
      out_val_q  <= rd_val;
      out_mode_q <= mode_q;
      out_last_q <= is_prog || (burst_q == CH_W'(CHANNELS - 1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drum_ch_o     = out_ch_q;
  assign drum_value_o  = out_val_q;
  assign mode_now_o    = out_mode_q;
  assign last_in_run_o = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/mdt_matcher.sv =====
// Sysex byte store and byte-serial pattern matcher.
// Depends on mdt_pkg.
`default_nettype none

module mdt_matcher
  import mdt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_we_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output match_res_t      res_o
);

  logic [7:0]         hold_q [HOLD_LEN];
  logic [3:0]         count_q, count_d;
  logic [3:0]         len_q;
  logic [HOLD_W-1:0]  idx_q;
  logic [NUM_PAT-1:0] ok_q, cmp;
  logic               scan_q, done_q;
  logic               scan_end;
  logic [3:0]         len_new;

  assign count_d  = (count_q < 4'(COUNT_SAT)) ? count_q + 4'd1 : count_q;
  assign len_new  = count_d;
  assign scan_end = ((4'(idx_q) + 4'd1) == len_q) || (idx_q == HOLD_W'(HOLD_LEN - 1));

  // one held byte against every pattern per cycle
  always_comb begin
    logic [15:0] pe;
    cmp = '0;
    for (int k = 0; k < NUM_PAT; k++) begin
      pe     = pat_entry(3'(k), idx_q);
      cmp[k] = ((hold_q[idx_q] & pe[15:8]) == pe[7:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we_i && (count_q < 4'(HOLD_LEN))) begin
      hold_q[count_q[HOLD_W-1:0]] <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= 1'b0;
      done_q  <= 1'b0;
      len_q   <= '0;
      idx_q   <= '0;
      ok_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (byte_we_i) begin
        if (last_i) begin
          count_q <= '0;
          len_q   <= len_new;
          idx_q   <= '0;
          ok_q    <= '1;
          scan_q  <= 1'b1;
        end else begin
          count_q <= count_d;
        end
      end else if (scan_q) begin
        ok_q <= ok_q & cmp;
        if (scan_end) begin
          scan_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + HOLD_W'(1);
        end
      end
    end
  end

  always_comb begin
    logic gm, gm2, gs, xg;
    gm  = ok_q[PAT_GM]  && (len_q == LEN_GM);
    gm2 = ok_q[PAT_GM2] && (len_q == LEN_GM);
    gs  = ok_q[PAT_GS]  && (len_q == LEN_GS);
    xg  = ok_q[PAT_XG]  && (len_q == LEN_XG);
    res_o.done     = done_q;
    res_o.rst_hit  = gm || gm2 || gs || xg;
    priority if (xg) begin
      res_o.rst_mode = MODE_XG;
    end else if (gs) begin
      res_o.rst_mode = MODE_GS;
    end else if (gm2) begin
      res_o.rst_mode = MODE_GM2;
    end else begin
      res_o.rst_mode = MODE_GM;
    end
    res_o.part_hit = ok_q[PAT_PART] && (len_q == LEN_GS);
    res_o.part     = hold_q[6][CH_W-1:0];
    res_o.addr     = hold_q[7];
    res_o.value    = hold_q[8];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mdt_chan_tbl.sv =====
// Per-channel drum settings and GS part-to-channel map.
// Depends on mdt_pkg.
`default_nettype none

module mdt_chan_tbl
  import mdt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tbl_cmd_t        cmd_i,
  input  wire logic [CH_W-1:0] rd_ch_i,
  output logic      [7:0]      rd_val_o
);

  logic [7:0] drum_q [CHANNELS];
  logic [7:0] map_q  [CHANNELS];
  logic [7:0] tgt;

  assign tgt      = map_q[cmd_i.idx];
  assign rd_val_o = drum_q[rd_ch_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        drum_q[i] <= (CH_W'(i) == DRUM_CH) ? 8'd1 : 8'd0;
        map_q[i]  <= map_init(CH_W'(i));
      end
    end else begin
      unique case (cmd_i.op)
        TBL_RESTORE: begin
          for (int i = 0; i < CHANNELS; i++) begin
            drum_q[i] <= (CH_W'(i) == DRUM_CH) ? 8'd1 : 8'd0;
            map_q[i]  <= map_init(CH_W'(i));
          end
        end
        TBL_FLAG: begin
          drum_q[cmd_i.idx] <= cmd_i.val;
        end
        TBL_MAP: begin
          map_q[cmd_i.idx] <= cmd_i.val;
        end
        TBL_FLAG_MAPPED: begin
          if (tgt < 8'(CHANNELS)) begin
            drum_q[tgt[CH_W-1:0]] <= cmd_i.val;
          end
        end
        TBL_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
